// File: hdl/afv_pkg.sv
// Shared types, codes and constants for the animation frame table validator.
package afv_pkg;

  // Default build configuration
  localparam int CELL_WIDTH      = 128;
  localparam int CELL_HEIGHT     = 128;
  localparam int BYTES_PER_PIXEL = 2;
  localparam int MAX_FRAMES      = 1024;
  localparam int NUM_STATES      = 9;

  localparam int MIN_STATE_FRAMES = 2;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CMD_W    = 2;
  localparam int ERR_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W  = 11;
  localparam int STATES_W = 4;
  localparam int BOX_W    = 10;
  localparam int BYTES_W  = 22;

  localparam logic [BOX_W-1:0] BOX_EMPTY_LOW = '1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_STATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // Status codes
  localparam logic [ERR_W-1:0] ERR_OK          = 3'd0;
  localparam logic [ERR_W-1:0] ERR_FRAME_COUNT = 3'd1;
  localparam logic [ERR_W-1:0] ERR_LAYOUT      = 3'd2;
  localparam logic [ERR_W-1:0] ERR_GEOMETRY    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_RANGE       = 3'd4;
  localparam logic [ERR_W-1:0] ERR_ORDER       = 3'd5;
  localparam logic [ERR_W-1:0] ERR_STAGE       = 3'd6;
  localparam logic [ERR_W-1:0] ERR_NUM_STATES  = 3'd7;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECLARED_FRAME_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BLOB_SIZE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_LEFT           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_TOP            = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_WIDTH          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_HEIGHT         = 3'd5;

  typedef struct packed {
    logic [COUNT_W-1:0] declared_frame_count;
    logic [31:0]        pixel_blob_size;
    logic [15:0]        stage_left;
    logic [15:0]        stage_top;
    logic [15:0]        stage_width;
    logic [15:0]        stage_height;
  } cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [15:0]      first_frame;
    logic [15:0]      frame_total;
    logic             geom_bad;
    logic             range_bad;
    logic             misaligned;
    logic [31:0]      data_offset;
    logic [31:0]      data_end;
    logic [BOX_W-1:0] x_lo;
    logic [BOX_W-1:0] y_lo;
    logic [BOX_W-1:0] x_hi;
    logic [BOX_W-1:0] y_hi;
  } entry_t;

endpackage

// File: hdl/afv_if.sv
// Channel interfaces: input items, result items and register writes.
interface afv_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd;
  logic [15:0]             first_frame;
  logic [15:0]             frame_total;
  logic signed [15:0]      crop_x;
  logic signed [15:0]      crop_y;
  logic signed [15:0]      crop_w;
  logic signed [15:0]      crop_h;
  logic [15:0]             hold_time;
  logic [31:0]             data_offset;

  modport source (
    output valid, cmd, first_frame, frame_total, crop_x, crop_y, crop_w, crop_h,
           hold_time, data_offset,
    input  ready
  );
  modport sink (
    input  valid, cmd, first_frame, frame_total, crop_x, crop_y, crop_w, crop_h,
           hold_time, data_offset,
    output ready
  );
endinterface

interface afv_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       is_verdict;

  modport source (output valid, status, is_verdict, input ready);
  modport sink (input valid, status, is_verdict, output ready);
endinterface

interface afv_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/animation_frame_table_validator.sv
// Top level of the animation frame table validator.
// Channels: in_i takes state records, frame records and finish items; out_o
// returns one result per item (the sticky status, and is_verdict for finish);
// cfg_i writes the six setup registers by index and is always ready.
// An item transfer on in_i lands in a four-entry queue after the front end
// classifies the crop, hold time and blob range. The back end takes one entry
// per cycle while the result register is empty or being taken, applies the
// stream checks and loads the result register, from which out_o offers it.
// Throughput is one item per cycle while out_o takes results, set by the
// back end updating the stream state as it pops each entry.
// When out_o stalls, the result register holds, the queue fills and in_i
// drops ready once four items are waiting; nothing is lost.
// Reset clears the stream state, the sticky error, the queue and the
// setup registers. Each finish item returns the stream state to its reset
// values after its verdict; the setup registers keep their values.
module animation_frame_table_validator #(
  parameter int CELL_WIDTH      = afv_pkg::CELL_WIDTH,
  parameter int CELL_HEIGHT     = afv_pkg::CELL_HEIGHT,
  parameter int BYTES_PER_PIXEL = afv_pkg::BYTES_PER_PIXEL,
  parameter int MAX_FRAMES      = afv_pkg::MAX_FRAMES,
  parameter int NUM_STATES      = afv_pkg::NUM_STATES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  afv_in_if.sink     in_i,
  afv_out_if.source  out_o,
  afv_cfg_if.sink    cfg_i
);

  afv_pkg::cfg_t   cfg;
  afv_pkg::entry_t push_entry, pop_entry;
  logic            push, full, pop, queued;

  afv_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  afv_front #(
    .CELL_WIDTH      (CELL_WIDTH),
    .CELL_HEIGHT     (CELL_HEIGHT),
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_front (
    .in_i    (in_i),
    .cfg_i   (cfg),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  afv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queued),
    .entry_o (pop_entry)
  );

  afv_back #(
    .MAX_FRAMES (MAX_FRAMES),
    .NUM_STATES (NUM_STATES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (queued),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: hdl/afv_cfg.sv
// Configuration register file.
module afv_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  afv_cfg_if.sink           cfg_i,
  output afv_pkg::cfg_t     cfg_o
);

  afv_pkg::cfg_t regs_q, regs_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        afv_pkg::REG_DECLARED_FRAME_COUNT:
          regs_d.declared_frame_count = cfg_i.data[afv_pkg::COUNT_W-1:0];
        afv_pkg::REG_PIXEL_BLOB_SIZE: regs_d.pixel_blob_size = cfg_i.data;
        afv_pkg::REG_STAGE_LEFT:      regs_d.stage_left = cfg_i.data[15:0];
        afv_pkg::REG_STAGE_TOP:       regs_d.stage_top = cfg_i.data[15:0];
        afv_pkg::REG_STAGE_WIDTH:     regs_d.stage_width = cfg_i.data[15:0];
        afv_pkg::REG_STAGE_HEIGHT:    regs_d.stage_height = cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

// File: hdl/afv_front.sv
// Front end: accepts items and classifies the stateless frame checks.
module afv_front #(
  parameter int CELL_WIDTH      = afv_pkg::CELL_WIDTH,
  parameter int CELL_HEIGHT     = afv_pkg::CELL_HEIGHT,
  parameter int BYTES_PER_PIXEL = afv_pkg::BYTES_PER_PIXEL
) (
  afv_in_if.sink            in_i,
  input  afv_pkg::cfg_t     cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output afv_pkg::entry_t   entry_o
);

  logic signed [16:0] x_hi, y_hi;
  logic               size_bad, pos_bad, edge_bad;
  logic [afv_pkg::BYTES_W-1:0] area, bytes;
  logic [31:0]        bytes32, room;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    x_hi = $signed({in_i.crop_x[15], in_i.crop_x}) + $signed({in_i.crop_w[15], in_i.crop_w});
    y_hi = $signed({in_i.crop_y[15], in_i.crop_y}) + $signed({in_i.crop_h[15], in_i.crop_h});
    size_bad = in_i.crop_w[15] || (in_i.crop_w == '0) ||
               in_i.crop_h[15] || (in_i.crop_h == '0);
    pos_bad  = in_i.crop_x[15] || in_i.crop_y[15];
    edge_bad = (x_hi > $signed(17'(CELL_WIDTH))) || (y_hi > $signed(17'(CELL_HEIGHT)));

    // Only meaningful when geometry passes, so both sides fit in 10 bits
    area    = afv_pkg::BYTES_W'(in_i.crop_w[9:0]) * afv_pkg::BYTES_W'(in_i.crop_h[9:0]);
    bytes   = afv_pkg::BYTES_W'(area * afv_pkg::BYTES_W'(BYTES_PER_PIXEL));
    bytes32 = 32'(bytes);
    room    = cfg_i.pixel_blob_size - in_i.data_offset;

    entry_o.cmd         = in_i.cmd;
    entry_o.first_frame = in_i.first_frame;
    entry_o.frame_total = in_i.frame_total;
    entry_o.geom_bad    = size_bad || pos_bad || edge_bad || (in_i.hold_time == '0);
    entry_o.range_bad   = (in_i.data_offset > cfg_i.pixel_blob_size) || (bytes32 > room);
    entry_o.misaligned  = (in_i.data_offset[1:0] != 2'b00);
    entry_o.data_offset = in_i.data_offset;
    entry_o.data_end    = in_i.data_offset + bytes32;
    entry_o.x_lo        = in_i.crop_x[afv_pkg::BOX_W-1:0];
    entry_o.y_lo        = in_i.crop_y[afv_pkg::BOX_W-1:0];
    entry_o.x_hi        = x_hi[afv_pkg::BOX_W-1:0];
    entry_o.y_hi        = y_hi[afv_pkg::BOX_W-1:0];
  end

endmodule

// File: hdl/afv_fifo.sv
// Short queue of classified items between front and back.
module afv_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  afv_pkg::entry_t   entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output afv_pkg::entry_t   entry_o
);

  localparam int PtrW = afv_pkg::QUEUE_PTR_W;

  afv_pkg::entry_t   mem_q [afv_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d;

  assign full_o  = (count_q == (PtrW+1)'(afv_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(afv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(afv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: hdl/afv_back.sv
// Back end: stream state, sticky error and the result register.
module afv_back #(
  parameter int MAX_FRAMES = afv_pkg::MAX_FRAMES,
  parameter int NUM_STATES = afv_pkg::NUM_STATES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  afv_pkg::cfg_t     cfg_i,
  input  logic              valid_i,
  input  afv_pkg::entry_t   entry_i,
  output logic              pop_o,
  afv_out_if.source         out_o
);

  localparam int CntW = afv_pkg::COUNT_W;
  localparam int BoxW = afv_pkg::BOX_W;

  logic [CntW-1:0]              next_first_q, next_first_d;
  logic [15:0]                  frames_left_q, frames_left_d;
  logic [CntW-1:0]              frames_seen_q, frames_seen_d;
  logic [afv_pkg::STATES_W-1:0] states_seen_q, states_seen_d;
  logic [31:0]                  prev_end_q, prev_end_d;
  logic [BoxW-1:0]              box_left_q, box_left_d, box_top_q, box_top_d;
  logic [BoxW-1:0]              box_right_q, box_right_d, box_bottom_q, box_bottom_d;
  logic [afv_pkg::ERR_W-1:0]    sticky_q, sticky_d, err;
  logic                         out_valid_q, out_valid_d;
  logic [afv_pkg::ERR_W-1:0]    status_q;
  logic                         verdict_q;
  logic                         stage_bad;

  assign pop_o            = valid_i && (!out_valid_q || out_o.ready);
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.is_verdict = verdict_q;

  always_comb begin
    next_first_d  = next_first_q;
    frames_left_d = frames_left_q;
    frames_seen_d = frames_seen_q;
    states_seen_d = states_seen_q;
    prev_end_d    = prev_end_q;
    box_left_d    = box_left_q;
    box_top_d     = box_top_q;
    box_right_d   = box_right_q;
    box_bottom_d  = box_bottom_q;
    sticky_d      = sticky_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    err           = sticky_q;

    stage_bad = (box_right_q <= box_left_q) || (box_bottom_q <= box_top_q) ||
                (cfg_i.stage_left != 16'(box_left_q)) ||
                (cfg_i.stage_top != 16'(box_top_q)) ||
                (cfg_i.stage_width != 16'(box_right_q - box_left_q)) ||
                (cfg_i.stage_height != 16'(box_bottom_q - box_top_q));

    if (pop_o) begin
      out_valid_d = 1'b1;
      if (entry_i.cmd != afv_pkg::CMD_NONE && sticky_q == afv_pkg::ERR_OK) begin
        if (cfg_i.declared_frame_count == '0 ||
            cfg_i.declared_frame_count > CntW'(MAX_FRAMES)) begin
          err = afv_pkg::ERR_FRAME_COUNT;
        end else begin
          case (entry_i.cmd)
            afv_pkg::CMD_STATE: begin
              if (states_seen_q >= afv_pkg::STATES_W'(NUM_STATES)) begin
                err = afv_pkg::ERR_NUM_STATES;
              end else if (frames_left_q != '0 ||
                           entry_i.frame_total < 16'(afv_pkg::MIN_STATE_FRAMES) ||
                           entry_i.first_frame != 16'(next_first_q)) begin
                err = afv_pkg::ERR_LAYOUT;
              end else begin
                states_seen_d = states_seen_q + 1'b1;
                frames_left_d = entry_i.frame_total;
              end
            end
            afv_pkg::CMD_FRAME: begin
              if (frames_left_q == '0) begin
                err = afv_pkg::ERR_LAYOUT;
              end else if (frames_seen_q >= cfg_i.declared_frame_count) begin
                err = afv_pkg::ERR_FRAME_COUNT;
              end else if (entry_i.geom_bad) begin
                err = afv_pkg::ERR_GEOMETRY;
              end else if (entry_i.range_bad) begin
                err = afv_pkg::ERR_RANGE;
              end else if (entry_i.data_offset < prev_end_q || entry_i.misaligned) begin
                err = afv_pkg::ERR_ORDER;
              end else begin
                prev_end_d = entry_i.data_end;
                if (entry_i.x_lo < box_left_q)   box_left_d   = entry_i.x_lo;
                if (entry_i.y_lo < box_top_q)    box_top_d    = entry_i.y_lo;
                if (entry_i.x_hi > box_right_q)  box_right_d  = entry_i.x_hi;
                if (entry_i.y_hi > box_bottom_q) box_bottom_d = entry_i.y_hi;
                frames_left_d = frames_left_q - 1'b1;
                frames_seen_d = frames_seen_q + 1'b1;
                next_first_d  = next_first_q + 1'b1;
              end
            end
            afv_pkg::CMD_FINISH: begin
              if (states_seen_q != afv_pkg::STATES_W'(NUM_STATES)) begin
                err = afv_pkg::ERR_NUM_STATES;
              end else if (frames_left_q != '0) begin
                err = afv_pkg::ERR_LAYOUT;
              end else if (frames_seen_q != cfg_i.declared_frame_count) begin
                err = afv_pkg::ERR_FRAME_COUNT;
              end else if (stage_bad) begin
                err = afv_pkg::ERR_STAGE;
              end
            end
            default: ;
          endcase
        end
      end
      sticky_d = err;
      if (entry_i.cmd == afv_pkg::CMD_FINISH) begin
        next_first_d  = '0;
        frames_left_d = '0;
        frames_seen_d = '0;
        states_seen_d = '0;
        prev_end_d    = '0;
        box_left_d    = afv_pkg::BOX_EMPTY_LOW;
        box_top_d     = afv_pkg::BOX_EMPTY_LOW;
        box_right_d   = '0;
        box_bottom_d  = '0;
        sticky_d      = afv_pkg::ERR_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_first_q  <= '0;
      frames_left_q <= '0;
      frames_seen_q <= '0;
      states_seen_q <= '0;
      prev_end_q    <= '0;
      box_left_q    <= afv_pkg::BOX_EMPTY_LOW;
      box_top_q     <= afv_pkg::BOX_EMPTY_LOW;
      box_right_q   <= '0;
      box_bottom_q  <= '0;
      sticky_q      <= afv_pkg::ERR_OK;
      out_valid_q   <= 1'b0;
    end else begin
      next_first_q  <= next_first_d;
      frames_left_q <= frames_left_d;
      frames_seen_q <= frames_seen_d;
      states_seen_q <= states_seen_d;
      prev_end_q    <= prev_end_d;
      box_left_q    <= box_left_d;
      box_top_q     <= box_top_d;
      box_right_q   <= box_right_d;
      box_bottom_q  <= box_bottom_d;
      sticky_q      <= sticky_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q  <= err;
      verdict_q <= (entry_i.cmd == afv_pkg::CMD_FINISH);
    end
  end

endmodule

// File: test/testbench.sv
// Testbench for the animation frame table validator: directed, noise and random table packages.
module testbench;
  import afv_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] first_frame;
    logic [15:0] frame_total;
    logic [15:0] crop_x;
    logic [15:0] crop_y;
    logic [15:0] crop_w;
    logic [15:0] crop_h;
    logic [15:0] hold_time;
    logic [31:0] data_offset;
  } record_t;

  typedef struct packed {
    logic [2:0] status;
    logic       is_verdict;
  } outcome_t;

  logic clk;
  logic rst_n;

  afv_in_if  in_if ();
  afv_out_if out_if ();
  afv_cfg_if cfg_if ();

  animation_frame_table_validator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // setup registers as the block should hold them
  logic [10:0] s_declared;
  logic [31:0] s_blob;
  logic [15:0] s_left, s_top, s_width, s_height;

  // stream state tracked alongside the block
  logic [10:0] t_next_first;
  logic [15:0] t_frames_due;
  logic [10:0] t_frames_counted;
  logic [3:0]  t_states;
  logic [31:0] t_data_end;
  logic [9:0]  t_box_l, t_box_t, t_box_r, t_box_b;
  logic [2:0]  t_error;

  outcome_t status_due_q[$];
  outcome_t want;

  int cycle_count;
  int fail_count;
  int shown_count;
  int sent_count;
  int checked_count;
  int verdict_count;
  int package_count;
  int burst_left;
  int rx_run;
  bit rx_stall;
  bit rx_stalls_on;
  bit tx_gaps_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             status_due_q.size());
    $display("status: fail");
    $finish;
  end

  function automatic void clear_tracking();
    t_next_first     = '0;
    t_frames_due     = '0;
    t_frames_counted = '0;
    t_states         = '0;
    t_data_end       = '0;
    t_box_l          = '1;
    t_box_t          = '1;
    t_box_r          = '0;
    t_box_b          = '0;
    t_error          = ERR_OK;
  endfunction

  function automatic logic [2:0] state_outcome(record_t r);
    if (t_states >= NUM_STATES) return ERR_NUM_STATES;
    if (t_frames_due != 0) return ERR_LAYOUT;
    if (r.frame_total < MIN_STATE_FRAMES) return ERR_LAYOUT;
    if (r.first_frame != {5'd0, t_next_first}) return ERR_LAYOUT;
    t_states     = t_states + 4'd1;
    t_frames_due = r.frame_total;
    return ERR_OK;
  endfunction

  function automatic logic [2:0] frame_outcome(record_t r);
    int x, y, w, h;
    logic [31:0] bytes;
    x = $signed(r.crop_x);
    y = $signed(r.crop_y);
    w = $signed(r.crop_w);
    h = $signed(r.crop_h);
    if (t_frames_due == 0) return ERR_LAYOUT;
    if (t_frames_counted >= s_declared) return ERR_FRAME_COUNT;
    if (w <= 0 || h <= 0) return ERR_GEOMETRY;
    if (x < 0 || y < 0 || x + w > CELL_WIDTH || y + h > CELL_HEIGHT) return ERR_GEOMETRY;
    if (r.hold_time == 0) return ERR_GEOMETRY;
    bytes = 32'(w * h * BYTES_PER_PIXEL);
    if (r.data_offset > s_blob || bytes > s_blob - r.data_offset) return ERR_RANGE;
    if (r.data_offset < t_data_end || r.data_offset[1:0] != 2'b00) return ERR_ORDER;
    t_data_end = r.data_offset + bytes;
    if (x < int'(t_box_l)) t_box_l = 10'(x);
    if (y < int'(t_box_t)) t_box_t = 10'(y);
    if (x + w > int'(t_box_r)) t_box_r = 10'(x + w);
    if (y + h > int'(t_box_b)) t_box_b = 10'(y + h);
    t_frames_due     = t_frames_due - 16'd1;
    t_frames_counted = t_frames_counted + 11'd1;
    t_next_first     = t_next_first + 11'd1;
    return ERR_OK;
  endfunction

  function automatic logic [2:0] finish_outcome();
    if (t_states != NUM_STATES) return ERR_NUM_STATES;
    if (t_frames_due != 0) return ERR_LAYOUT;
    if (t_frames_counted != s_declared) return ERR_FRAME_COUNT;
    if (t_box_r <= t_box_l || t_box_b <= t_box_t) return ERR_STAGE;
    if (s_left != {6'd0, t_box_l} || s_top != {6'd0, t_box_t} ||
        s_width != {6'd0, 10'(t_box_r - t_box_l)} ||
        s_height != {6'd0, 10'(t_box_b - t_box_t)})
      return ERR_STAGE;
    return ERR_OK;
  endfunction

  function automatic outcome_t judge_record(record_t r);
    outcome_t o;
    if (r.cmd != CMD_NONE && t_error == ERR_OK &&
        (s_declared == 0 || s_declared > MAX_FRAMES))
      t_error = ERR_FRAME_COUNT;
    if (r.cmd != CMD_NONE && t_error == ERR_OK) begin
      case (r.cmd)
        CMD_STATE: t_error = state_outcome(r);
        CMD_FRAME: t_error = frame_outcome(r);
        default: t_error = finish_outcome();
      endcase
    end
    o.status     = t_error;
    o.is_verdict = (r.cmd == CMD_FINISH);
    if (r.cmd == CMD_FINISH) clear_tracking();
    return o;
  endfunction

  function automatic record_t bus_record();
    record_t r;
    r.cmd         = in_if.cmd;
    r.first_frame = in_if.first_frame;
    r.frame_total = in_if.frame_total;
    r.crop_x      = in_if.crop_x;
    r.crop_y      = in_if.crop_y;
    r.crop_w      = in_if.crop_w;
    r.crop_h      = in_if.crop_h;
    r.hold_time   = in_if.hold_time;
    r.data_offset = in_if.data_offset;
    return r;
  endfunction

  // transfers seen at the rising edge: setup writes, item predictions, result checks
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_DECLARED_FRAME_COUNT: s_declared = cfg_if.data[10:0];
          REG_PIXEL_BLOB_SIZE:      s_blob     = cfg_if.data;
          REG_STAGE_LEFT:           s_left     = cfg_if.data[15:0];
          REG_STAGE_TOP:            s_top      = cfg_if.data[15:0];
          REG_STAGE_WIDTH:          s_width    = cfg_if.data[15:0];
          REG_STAGE_HEIGHT:         s_height   = cfg_if.data[15:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) status_due_q.push_back(judge_record(bus_record()));
      if (out_if.valid && out_if.ready) begin
        checked_count++;
        if (out_if.is_verdict === 1'b1) verdict_count++;
        if (status_due_q.size() == 0) begin
          fail_count++;
          if (shown_count < 10) begin
            $display("unexpected result: status %0d verdict %0d", out_if.status,
                     out_if.is_verdict);
            shown_count++;
          end
        end else begin
          want = status_due_q.pop_front();
          if (out_if.status !== want.status || out_if.is_verdict !== want.is_verdict) begin
            fail_count++;
            if (shown_count < 10) begin
              $display("mismatch at result %0d: expected status %0d verdict %0d, got %0d %0d",
                       checked_count, want.status, want.is_verdict, out_if.status,
                       out_if.is_verdict);
              shown_count++;
            end
          end
        end
      end
    end
  end

  // receiver backpressure: runs of ready and stalled cycles
  always @(negedge clk) begin
    if (rx_run == 0) begin
      rx_stall = rx_stalls_on && ($urandom_range(0, 2) == 0);
      rx_run   = rx_stall ? $urandom_range(1, 12) : $urandom_range(1, 10);
    end
    rx_run--;
    out_if.ready <= !rx_stall;
  end

  function automatic record_t state_rec(int first, int total);
    record_t r;
    r             = '0;
    r.cmd         = CMD_STATE;
    r.first_frame = 16'(first);
    r.frame_total = 16'(total);
    return r;
  endfunction

  function automatic record_t frame_rec(int x, int y, int w, int h, int hold,
                                        logic [31:0] offset);
    record_t r;
    r             = '0;
    r.cmd         = CMD_FRAME;
    r.crop_x      = 16'(x);
    r.crop_y      = 16'(y);
    r.crop_w      = 16'(w);
    r.crop_h      = 16'(h);
    r.hold_time   = 16'(hold);
    r.data_offset = offset;
    return r;
  endfunction

  function automatic record_t cmd_rec(logic [1:0] cmd);
    record_t r;
    r     = '0;
    r.cmd = cmd;
    return r;
  endfunction

  function automatic record_t random_record();
    record_t r;
    r.cmd         = 2'($urandom_range(0, 3));
    r.first_frame = 16'($urandom);
    r.frame_total = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4)) : 16'($urandom);
    r.crop_x      = 16'($urandom);
    r.crop_y      = 16'($urandom);
    r.crop_w      = 16'($urandom);
    r.crop_h      = 16'($urandom);
    r.hold_time   = 16'($urandom);
    r.data_offset = $urandom;
    return r;
  endfunction

  task automatic send_record(input record_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (tx_gaps_on) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid       <= 1'b1;
    in_if.cmd         <= r.cmd;
    in_if.first_frame <= r.first_frame;
    in_if.frame_total <= r.frame_total;
    in_if.crop_x      <= r.crop_x;
    in_if.crop_y      <= r.crop_y;
    in_if.crop_w      <= r.crop_w;
    in_if.crop_h      <= r.crop_h;
    in_if.hold_time   <= r.hold_time;
    in_if.data_offset <= r.data_offset;
    do @(posedge clk); while (!in_if.ready);
    sent_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic write_setup(input logic [10:0] declared, input logic [31:0] blob,
                             input logic [15:0] left, input logic [15:0] top,
                             input logic [15:0] width, input logic [15:0] height);
    write_reg(REG_DECLARED_FRAME_COUNT, {21'd0, declared});
    write_reg(REG_PIXEL_BLOB_SIZE, blob);
    write_reg(REG_STAGE_LEFT, {16'd0, left});
    write_reg(REG_STAGE_TOP, {16'd0, top});
    write_reg(REG_STAGE_WIDTH, {16'd0, width});
    write_reg(REG_STAGE_HEIGHT, {16'd0, height});
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_unconfigured();
    send_record(frame_rec(0, 0, 1, 1, 1, 32'd0));
    send_record(cmd_rec(CMD_NONE));
    send_record(cmd_rec(CMD_FINISH));
    wait_drained();
  endtask

  task automatic test_layout_errors();
    write_setup(11'd2047, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_record(state_rec(0, 2));
    send_record(cmd_rec(CMD_FINISH));
    wait_drained();
    write_setup(11'd1024, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd128, 16'd128);
    send_record(frame_rec(0, 0, 4, 4, 1, 32'd0));
    send_record(cmd_rec(CMD_FINISH));
    send_record(state_rec(0, 1));
    send_record(cmd_rec(CMD_FINISH));
    send_record(state_rec(5, 2));
    send_record(cmd_rec(CMD_FINISH));
    send_record(state_rec(0, 2));
    send_record(state_rec(2, 2));
    send_record(cmd_rec(CMD_FINISH));
    wait_drained();
  endtask

  task automatic test_frame_errors();
    write_setup(11'd1, 32'd32768, 16'd0, 16'd0, 16'd128, 16'd128);
    send_record(state_rec(0, 2));
    send_record(frame_rec(0, 0, CELL_WIDTH, CELL_HEIGHT, 65535, 32'd0));
    send_record(frame_rec(0, 0, 1, 1, 1, 32'd32768));
    send_record(cmd_rec(CMD_FINISH));
    wait_drained();
    write_setup(11'd1024, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd128, 16'd128);
    send_record(state_rec(0, 3));
    send_record(frame_rec(0, 0, -32768, 4, 1, 32'd0));
    send_record(cmd_rec(CMD_FINISH));
    send_record(state_rec(0, 2));
    send_record(frame_rec(127, 127, 1, 1, 1, 32'hFFFF_FFFC));
    send_record(frame_rec(127, 127, 1, 1, 1, 32'hFFFF_FFFE));
    send_record(cmd_rec(CMD_FINISH));
    send_record(state_rec(0, 2));
    send_record(frame_rec(-1, 0, 2, 2, 7, 32'd2));
    send_record(cmd_rec(CMD_FINISH));
    wait_drained();
  endtask

  task automatic test_noise();
    int round;
    for (round = 0; round < 2; round++) begin
      tx_gaps_on   = (round == 0);
      rx_stalls_on = 1'b1;
      write_setup(round == 0 ? 11'($urandom_range(0, 2047)) : 11'($urandom_range(1, 8)),
                  $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      repeat (75) send_record(random_record());
      send_record(cmd_rec(CMD_FINISH));
      wait_drained();
    end
  endtask

  // one table package, well formed unless broken on purpose
  task automatic run_package(input bit broken);
    record_t pkg_q[$];
    record_t r;
    int s, f, first, total, x, y, w, h, bl, bt, br, bb, pos;
    logic [31:0] data_end, offset, blob;
    logic [10:0] declared;
    logic [15:0] st_l, st_t, st_w, st_h;
    first    = 0;
    data_end = ($urandom_range(0, 3) == 0) ? 32'(4 * $urandom_range(0, 1024)) : 32'd0;
    bl = 1023; bt = 1023; br = 0; bb = 0;
    for (s = 0; s < NUM_STATES; s++) begin
      total = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 12) : $urandom_range(2, 4);
      pkg_q.push_back(state_rec(first, total));
      for (f = 0; f < total; f++) begin
        if ($urandom_range(0, 15) == 0) begin
          x = 0; y = 0; w = CELL_WIDTH; h = CELL_HEIGHT;
        end else begin
          x = $urandom_range(0, CELL_WIDTH - 1);
          y = $urandom_range(0, CELL_HEIGHT - 1);
          w = $urandom_range(1, CELL_WIDTH - x);
          h = $urandom_range(1, CELL_HEIGHT - y);
        end
        offset = ((data_end + 32'd3) & ~32'd3) + 32'(4 * $urandom_range(0, 3));
        pkg_q.push_back(frame_rec(x, y, w, h, $urandom_range(1, 65535), offset));
        data_end = offset + 32'(w * h * BYTES_PER_PIXEL);
        if (x < bl) bl = x;
        if (y < bt) bt = y;
        if (x + w > br) br = x + w;
        if (y + h > bb) bb = y + h;
      end
      first += total;
    end
    pkg_q.push_back(cmd_rec(CMD_FINISH));
    declared = 11'(first);
    blob     = data_end + (($urandom_range(0, 2) == 0) ? 32'd0 : 32'(4 * $urandom_range(1, 64)));
    st_l = 16'(bl); st_t = 16'(bt); st_w = 16'(br - bl); st_h = 16'(bb - bt);
    if (broken) begin
      pos = $urandom_range(0, pkg_q.size() - 2);
      case ($urandom_range(0, 5))
        0: begin
          r = pkg_q[pos];
          case ($urandom_range(0, 6))
            0: r.cmd = 2'($urandom_range(0, 3));
            1: r.crop_x = 16'($urandom);
            2: r.crop_w = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
            3: r.hold_time = 16'd0;
            4: r.data_offset = r.data_offset + 32'($urandom_range(1, 3));
            5: r.frame_total = 16'($urandom_range(0, 3));
            default: r.first_frame = r.first_frame + 16'd1;
          endcase
          pkg_q[pos] = r;
        end
        1: declared = ($urandom_range(0, 1) == 0) ? declared - 11'd1 : declared + 11'd1;
        2: begin
          case ($urandom_range(0, 3))
            0: st_l = st_l + 16'd1;
            1: st_t = st_t + 16'd1;
            2: st_w = st_w + 16'd1;
            default: st_h = st_h - 16'd1;
          endcase
        end
        3: blob = data_end - 32'($urandom_range(1, 4));
        4: pkg_q.delete(pos);
        default: pkg_q.insert(pkg_q.size() - 1, state_rec(first, 2));
      endcase
    end
    write_setup(declared, blob, st_l, st_t, st_w, st_h);
    foreach (pkg_q[i]) send_record(pkg_q[i]);
    wait_drained();
    package_count++;
  endtask

  task automatic test_packages();
    int start;
    start = sent_count;
    while (sent_count - start < RANDOM_ITEMS) begin
      if (package_count % 6 == 5) begin
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
      end else begin
        tx_gaps_on   = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
      end
      run_package($urandom_range(0, 9) < 4);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_NONE;
    in_if.first_frame = '0;
    in_if.frame_total = '0;
    in_if.crop_x      = '0;
    in_if.crop_y      = '0;
    in_if.crop_w      = '0;
    in_if.crop_h      = '0;
    in_if.hold_time   = '0;
    in_if.data_offset = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    s_declared = '0; s_blob = '0;
    s_left = '0; s_top = '0; s_width = '0; s_height = '0;
    clear_tracking();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_unconfigured();
    test_layout_errors();
    test_frame_errors();
    test_noise();
    test_packages();

    wait_drained();
    repeat (4) @(posedge clk);
    $display("sent %0d items: directed cases, random noise and %0d table packages",
             sent_count, package_count);
    $display("checked %0d results, %0d verdicts, %0d failures", checked_count,
             verdict_count, fail_count);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
hdl/afv_pkg.sv
hdl/afv_if.sv
hdl/afv_cfg.sv
hdl/afv_front.sv
hdl/afv_fifo.sv
hdl/afv_back.sv
hdl/animation_frame_table_validator.sv
test/testbench.sv
